[rtl/core/rgb_led_effect_controller_unit_defines.svh]
// Assertion macros for the RGB LED effect controller.
// Included by the top level; no other dependencies.
`ifndef RGB_LED_EFFECT_CONTROLLER_UNIT_DEFINES_SVH
`define RGB_LED_EFFECT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLEC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rlec_pkg.sv]
// Shared types, codes and lookup tables of the RGB LED effect controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rlec_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SHOW  = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Effect codes
  localparam logic [2:0] EFF_CONSTANT    = 3'd0;
  localparam logic [2:0] EFF_BLINK       = 3'd1;
  localparam logic [2:0] EFF_FAST_BLINK  = 3'd2;
  localparam logic [2:0] EFF_BREATH      = 3'd3;
  localparam logic [2:0] EFF_FAST_BREATH = 3'd4;
  localparam logic [2:0] EFF_OFF         = 3'd5;

  // Color codes used by the system-state table
  localparam logic [2:0] COL_WHITE   = 3'd0;
  localparam logic [2:0] COL_RED     = 3'd1;
  localparam logic [2:0] COL_YELLOW  = 3'd2;
  localparam logic [2:0] COL_BLUE    = 3'd3;
  localparam logic [2:0] COL_GREEN   = 3'd4;
  localparam logic [2:0] COL_MAGENTA = 3'd5;
  localparam logic [2:0] COL_CYAN    = 3'd6;

  // System states
  localparam logic [3:0] SYS_INIT       = 4'd0;
  localparam logic [3:0] SYS_RUNNING    = 4'd1;
  localparam logic [3:0] SYS_ON_BATTERY = 4'd2;
  localparam logic [3:0] SYS_LOW_BATT   = 4'd3;
  localparam logic [3:0] SYS_UPDATE     = 4'd4;
  localparam logic [3:0] SYS_ERROR      = 4'd5;
  localparam logic [3:0] SYS_SETUP      = 4'd6;
  localparam logic [3:0] SYS_SLEEP      = 4'd7;
  localparam logic [3:0] SYS_RESET      = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_FULL_BRIGHTNESS   = 3'd0;
  localparam logic [2:0] REG_PULSE_SCALE       = 3'd1;
  localparam logic [2:0] REG_RAMP_STEP         = 3'd2;
  localparam logic [2:0] REG_BLINK_TICKS       = 3'd3;
  localparam logic [2:0] REG_FAST_BLINK_TICKS  = 3'd4;
  localparam logic [2:0] REG_BREATH_STEP_TICKS = 3'd5;
  localparam logic [2:0] REG_FAST_PAUSE_TICKS  = 3'd6;
  localparam logic [2:0] REG_IDLE_STATE        = 3'd7;

  // x / 100 == (x * 5243) >> 19, exact for x < 2^15
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  localparam logic [6:0] BRIGHT_RESET = 7'd90;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_SHOW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] color;
    logic [2:0] effect;
  } cmd_t;

  typedef struct packed {
    logic [6:0] full_brightness;
    logic [7:0] pulse_scale;
    logic [5:0] ramp_step;
    logic [7:0] blink_ticks;
    logic [7:0] fast_blink_ticks;
    logic [7:0] breath_step_ticks;
    logic [7:0] fast_pause_ticks;
    logic       idle_state;
  } cfg_t;

  // Which components are lit: {red, green, blue}; code 7 is black
  function automatic logic [2:0] rlec_rgb_on(input logic [2:0] col);
    logic [2:0] on;
    case (col)
      COL_WHITE:   on = 3'b111;
      COL_RED:     on = 3'b100;
      COL_YELLOW:  on = 3'b110;
      COL_BLUE:    on = 3'b001;
      COL_GREEN:   on = 3'b010;
      COL_MAGENTA: on = 3'b101;
      COL_CYAN:    on = 3'b011;
      default:     on = 3'b000;
    endcase
    return on;
  endfunction

  // System state to {color, effect}
  function automatic logic [5:0] rlec_state_map(input logic [3:0] st);
    logic [5:0] m;
    case (st)
      SYS_INIT:       m = {COL_GREEN,   EFF_CONSTANT};
      SYS_RUNNING:    m = {COL_CYAN,    EFF_CONSTANT};
      SYS_ON_BATTERY: m = {COL_CYAN,    EFF_BREATH};
      SYS_LOW_BATT:   m = {COL_YELLOW,  EFF_BREATH};
      SYS_UPDATE:     m = {COL_MAGENTA, EFF_BLINK};
      SYS_ERROR:      m = {COL_RED,     EFF_BLINK};
      SYS_SETUP:      m = {COL_BLUE,    EFF_CONSTANT};
      SYS_SLEEP:      m = {COL_WHITE,   EFF_OFF};
      SYS_RESET:      m = {COL_RED,     EFF_CONSTANT};
      default:        m = {COL_WHITE,   EFF_CONSTANT};
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/rlec_front.sv]
// Front end: decodes input transactions into effect commands.
// Depends on rlec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlec_front
  import rlec_pkg::*;
(
  input  wire logic [1:0] operation_i,
  input  wire logic [2:0] color_i,
  input  wire logic [2:0] effect_i,
  input  wire logic [3:0] system_state_i,
  input  wire logic       idle_state_i,
  output cmd_t            cmd_o
);

  logic [5:0] map;

  assign map = rlec_state_map(system_state_i);

  always_comb begin
    cmd_o.kind   = CMD_NOP;
    cmd_o.color  = color_i;
    cmd_o.effect = effect_i;
    case (operation_i)
      OP_TICK: cmd_o.kind = CMD_TICK;
      OP_SHOW: cmd_o.kind = CMD_SHOW;
      OP_EVENT: begin
        // unknown system states become a no-op
        if (system_state_i <= SYS_RESET) begin
          cmd_o.kind   = CMD_SHOW;
          cmd_o.color  = map[5:3];
          cmd_o.effect = map[2:0];
          if (system_state_i == SYS_ON_BATTERY && !idle_state_i) begin
            cmd_o.effect = EFF_OFF;
          end
        end
      end
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/rlec_cmd_fifo.sv]
// Command queue between front end and effect engine.
// Depends on rlec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlec_cmd_fifo
  import rlec_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/rlec_back.sv]
// Effect engine: applies commands to the effect state, scales brightness
// into PWM compare values and holds the result register. Depends on rlec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rlec_back
  import rlec_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_pop_o,
  output logic [39:0]      data_o,
  output logic             valid_o,
  input  wire logic        ready_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e      state_q;
  logic        anim_q, anim_d;
  logic [2:0]  mode_q, mode_d;
  logic [2:0]  color_q, color_d;
  logic [6:0]  bright_q, bright_d;
  logic [6:0]  target_q, target_d;
  logic [7:0]  count_q, count_d;
  logic [14:0] prod_q;
  logic [39:0] data_q;

  // breath ramp step
  logic [7:0]  ramp_sum;
  logic        rising, ramp_done;
  logic [6:0]  ramp_b;
  logic [6:0]  rev_target;
  logic        fast_now, show_fast;

  // scaling
  logic [27:0] recip;
  logic [8:0]  scale;
  logic [7:0]  level;
  logic [2:0]  on;

  assign ramp_sum   = {1'b0, bright_q} + {2'b0, cfg_i.ramp_step};
  assign rising     = target_q > bright_q;
  assign fast_now   = (mode_q == EFF_FAST_BREATH);
  assign show_fast  = (cmd_i.effect == EFF_FAST_BREATH);
  assign rev_target = (ramp_b <= cfg_i.full_brightness) ?
                      cfg_i.full_brightness - ramp_b : '0;

  always_comb begin
    if (rising) begin
      ramp_done = ramp_sum >= {1'b0, target_q};
      ramp_b    = ramp_done ? target_q : ramp_sum[6:0];
    end else begin
      ramp_done = bright_q <= {1'b0, cfg_i.ramp_step};
      ramp_b    = ramp_done ? '0 : bright_q - {1'b0, cfg_i.ramp_step};
    end
  end

  // Next effect state for the command at the head of the queue
  always_comb begin
    anim_d   = anim_q;
    mode_d   = mode_q;
    color_d  = color_q;
    bright_d = bright_q;
    target_d = target_q;
    count_d  = count_q;
    case (cmd_i.kind)
      CMD_SHOW: begin
        case (cmd_i.effect)
          EFF_CONSTANT: begin
            anim_d   = 1'b0;
            color_d  = cmd_i.color;
            mode_d   = EFF_CONSTANT;
            bright_d = cfg_i.full_brightness;
          end
          EFF_BLINK, EFF_FAST_BLINK: begin
            anim_d   = 1'b1;
            color_d  = cmd_i.color;
            mode_d   = cmd_i.effect;
            count_d  = cfg_i.fast_blink_ticks;
            bright_d = cfg_i.full_brightness;
          end
          EFF_OFF: begin
            anim_d   = 1'b0;
            mode_d   = EFF_OFF;
            bright_d = '0;
          end
          default: begin
            // breath, fast breath and unused codes start a ramp from full
            anim_d   = 1'b1;
            color_d  = cmd_i.color;
            target_d = '0;
            bright_d = cfg_i.full_brightness;
            mode_d   = show_fast ? EFF_FAST_BREATH : EFF_BREATH;
            count_d  = show_fast ? cfg_i.fast_pause_ticks : cfg_i.breath_step_ticks;
          end
        endcase
      end
      CMD_TICK: begin
        if (anim_q) begin
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else if (mode_q == EFF_BLINK || mode_q == EFF_FAST_BLINK) begin
            count_d  = (mode_q == EFF_BLINK) ? cfg_i.blink_ticks : cfg_i.fast_blink_ticks;
            bright_d = (bright_q != '0) ? '0 : cfg_i.full_brightness;
          end else begin
            bright_d = ramp_b;
            count_d  = cfg_i.breath_step_ticks;
            if (ramp_done) begin
              // reversal: aim at full brightness minus where the ramp stopped
              target_d = rev_target;
              mode_d   = fast_now ? EFF_FAST_BREATH : EFF_BREATH;
              count_d  = fast_now ? cfg_i.fast_pause_ticks : cfg_i.breath_step_ticks;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign recip = 28'(prod_q) * 28'(DIV100_MUL);
  assign scale = recip[DIV100_SHIFT +: 9];
  assign level = (scale > 9'd255) ? 8'd255 : scale[7:0];
  assign on    = rlec_rgb_on(color_q);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign valid_o   = (state_q == ST_OUT);
  assign data_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      anim_q   <= 1'b0;
      mode_q   <= EFF_CONSTANT;
      color_q  <= COL_CYAN;
      bright_q <= BRIGHT_RESET;
      target_q <= '0;
      count_q  <= '0;
      prod_q   <= '0;
      data_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            anim_q   <= anim_d;
            mode_q   <= mode_d;
            color_q  <= color_d;
            bright_q <= bright_d;
            target_q <= target_d;
            count_q  <= count_d;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= 15'(bright_q) * 15'(cfg_i.pulse_scale);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          data_q  <= {6'b0, bright_q, mode_q,
                      on[0] ? level : 8'd0,
                      on[1] ? level : 8'd0,
                      on[2] ? level : 8'd0};
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/rgb_led_effect_controller_unit.sv]
// Top level of the RGB LED effect controller: configuration registers,
// front end, command queue and effect engine. Depends on rlec_pkg and
// rgb_led_effect_controller_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
// Drives the PWM compare values of one RGB LED. Each input transaction is
// a tick, a display command (color plus effect) or a system-state event
// mapped through a fixed table; every transaction yields exactly one result
// with the three compare values, the active effect and the brightness.
// Compare = min(255, component * (brightness * pulse_scale / 100) / 255).
// Timing: the front end decodes and queues a command in the accept cycle;
// the effect engine then steps through its states for each item (state
// update, brightness times pulse scale, reciprocal divide by 100 into the
// result register, and the state in which the result waits to be taken).
// It pops the next command only once the result is taken, so it holds one
// item at a time and a low m_axis_tready stalls it. Inputs keep being accepted into the
// CmdDepth-entry queue while a result waits downstream.
// Configuration writes are always ready and take effect the next cycle.
module rgb_led_effect_controller_unit
  import rlec_pkg::*;
#(
  parameter int unsigned CmdDepth = 2  // command queue entries, 2 or more
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: operation[1:0], color[4:2], effect[7:5], system_state[11:8], zero[15:12]
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: red_compare[7:0], green_compare[15:8], blue_compare[23:16],
  //        active_effect[26:24], brightness_now[33:27], zero[39:34]
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  logic queue_full, queue_valid, queue_pop;

  assign cfg_ready_o = 1'b1;

  // Register file; each write keeps only the register's own width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_brightness   <= 7'd90;
      cfg_q.pulse_scale       <= 8'd200;
      cfg_q.ramp_step         <= 6'd2;
      cfg_q.blink_ticks       <= 8'd30;
      cfg_q.fast_blink_ticks  <= 8'd15;
      cfg_q.breath_step_ticks <= 8'd5;
      cfg_q.fast_pause_ticks  <= 8'd2;
      cfg_q.idle_state        <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FULL_BRIGHTNESS:   cfg_q.full_brightness   <= cfg_data_i[6:0];
        REG_PULSE_SCALE:       cfg_q.pulse_scale       <= cfg_data_i;
        REG_RAMP_STEP:         cfg_q.ramp_step         <= cfg_data_i[5:0];
        REG_BLINK_TICKS:       cfg_q.blink_ticks       <= cfg_data_i;
        REG_FAST_BLINK_TICKS:  cfg_q.fast_blink_ticks  <= cfg_data_i;
        REG_BREATH_STEP_TICKS: cfg_q.breath_step_ticks <= cfg_data_i;
        REG_FAST_PAUSE_TICKS:  cfg_q.fast_pause_ticks  <= cfg_data_i;
        REG_IDLE_STATE:        cfg_q.idle_state        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front end: classify the transaction, idle_state gates the battery event
  rlec_front u_front (
    .operation_i    (s_axis_tdata[1:0]),
    .color_i        (s_axis_tdata[4:2]),
    .effect_i       (s_axis_tdata[7:5]),
    .system_state_i (s_axis_tdata[11:8]),
    .idle_state_i   (cfg_q.idle_state),
    .cmd_o          (front_cmd)
  );

  assign s_axis_tready = !queue_full;

  rlec_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .cmd_o   (queue_cmd),
    .valid_o (queue_valid)
  );

  // Back end: effect state, scaling and the output register
  rlec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_pop_o   (queue_pop),
    .data_o      (m_axis_tdata),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready)
  );

`include "rgb_led_effect_controller_unit_defines.svh"

  // Off always shows zero brightness
  `RLEC_ASSERT_IMP(a_off_dark, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[26:24] == EFF_OFF, m_axis_tdata[33:27] == 7'd0,
    "off effect with nonzero brightness")
  // Zero brightness means all compares are zero
  `RLEC_ASSERT_IMP(a_dark_zero, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[33:27] == 7'd0, m_axis_tdata[23:0] == 24'd0,
    "compare nonzero at zero brightness")
  // A taken result is never shown again in the next cycle
  `RLEC_ASSERT_NXT(a_single_result, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready, !m_axis_tvalid,
    "result transaction repeated")

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for rgb_led_effect_controller_unit: streams ticks,
// display commands and system-state events and checks every result against
// a built-in effect predictor. Depends on rlec_pkg and the DUT only.
`timescale 1ns / 1ps

module testbench;
  import rlec_pkg::*;

  // Codes outside the package lists, still legal on the wires
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] COL_BLACK = 3'd7;

  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned CYCLE_LIMIT     = 400_000;
  // long receiver hold-offs, triggered by result count
  localparam int unsigned HOLD_FIRST      = 480;
  localparam int unsigned HOLD_SECOND     = 1230;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;

  // input transaction, first field in the low bits
  typedef struct packed {
    logic [3:0] zero;
    logic [3:0] sys_state;
    logic [2:0] effect;
    logic [2:0] color;
    logic [1:0] op;
  } led_cmd_t;

  // result transaction, red_compare in the low bits
  typedef struct packed {
    logic [5:0] zero;
    logic [6:0] bright;
    logic [2:0] effect;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_out_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic [15:0] s_axis_tdata  = '0;  // op[1:0], color[4:2], effect[7:5], sys_state[11:8]
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;        // red, green, blue, effect[26:24], bright[33:27]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;

  rgb_led_effect_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Effect predictor: shadow registers plus the LED state
  // ---------------------------------------------------------------------
  cfg_t       led_cfg;
  logic       led_animating;
  logic [2:0] led_effect;
  logic [2:0] led_color;
  logic [6:0] led_bright;
  logic [6:0] led_target;
  logic [7:0] led_countdown;

  function automatic void led_reset();
    led_cfg.full_brightness   = 7'd90;
    led_cfg.pulse_scale       = 8'd200;
    led_cfg.ramp_step         = 6'd2;
    led_cfg.blink_ticks       = 8'd30;
    led_cfg.fast_blink_ticks  = 8'd15;
    led_cfg.breath_step_ticks = 8'd5;
    led_cfg.fast_pause_ticks  = 8'd2;
    led_cfg.idle_state        = 1'b1;
    led_animating = 1'b0;
    led_effect    = EFF_CONSTANT;
    led_color     = COL_CYAN;
    led_bright    = 7'd90;
    led_target    = '0;
    led_countdown = '0;
  endfunction

  // Starts a breath cycle; a restart after a ramp end aims the next ramp at
  // full brightness minus where the last ramp stopped (zero when above full).
  function automatic void breath_begin(logic restart_cycle, logic fast, logic [2:0] col);
    led_color = col;
    if (restart_cycle) begin
      led_animating = 1'b1;
      led_target    = '0;
      led_bright    = led_cfg.full_brightness;
    end else begin
      led_target = (led_bright <= led_cfg.full_brightness) ?
                   led_cfg.full_brightness - led_bright : 7'd0;
    end
    if (fast) begin
      led_effect    = EFF_FAST_BREATH;
      led_countdown = led_cfg.fast_pause_ticks;
    end else begin
      led_effect    = EFF_BREATH;
      led_countdown = led_cfg.breath_step_ticks;
    end
  endfunction

  // One breath step; returns 1 when the ramp has reached its end.
  // Anything not strictly rising falls toward zero.
  function automatic logic ramp_step_done();
    int unsigned nxt;
    if (led_target > led_bright) begin
      nxt = led_bright;
      nxt = nxt + led_cfg.ramp_step;
      if (nxt >= led_target) begin
        led_bright = led_target;
        return 1'b1;
      end
      led_bright = 7'(nxt);
      return 1'b0;
    end
    if (led_bright <= led_cfg.ramp_step) begin
      led_bright = '0;
      return 1'b1;
    end
    led_bright = led_bright - led_cfg.ramp_step;
    return 1'b0;
  endfunction

  function automatic void led_tick();
    if (!led_animating) return;
    if (led_countdown != 0) begin
      led_countdown--;
      return;
    end
    if (led_effect == EFF_BLINK || led_effect == EFF_FAST_BLINK) begin
      led_countdown = (led_effect == EFF_BLINK) ? led_cfg.blink_ticks : led_cfg.fast_blink_ticks;
      led_bright    = (led_bright != 0) ? 7'd0 : led_cfg.full_brightness;
    end else begin
      led_countdown = led_cfg.breath_step_ticks;
      if (ramp_step_done()) breath_begin(1'b0, led_effect == EFF_FAST_BREATH, led_color);
    end
  endfunction

  // Unknown effect codes fall into the breath branch; off keeps the color
  function automatic void led_show(logic [2:0] col, logic [2:0] eff);
    case (eff)
      EFF_CONSTANT: begin
        led_animating = 1'b0;
        led_color     = col;
        led_effect    = EFF_CONSTANT;
        led_bright    = led_cfg.full_brightness;
      end
      EFF_BLINK, EFF_FAST_BLINK: begin
        led_animating = 1'b1;
        led_color     = col;
        led_effect    = eff;
        led_countdown = led_cfg.fast_blink_ticks;
        led_bright    = led_cfg.full_brightness;
      end
      EFF_OFF: begin
        led_animating = 1'b0;
        led_effect    = EFF_OFF;
        led_bright    = '0;
      end
      default: breath_begin(1'b1, eff == EFF_FAST_BREATH, col);
    endcase
  endfunction

  function automatic void led_event(logic [3:0] st);
    logic [2:0] col;
    logic [2:0] eff;
    case (st)
      SYS_INIT:       begin col = COL_GREEN;   eff = EFF_CONSTANT; end
      SYS_RUNNING:    begin col = COL_CYAN;    eff = EFF_CONSTANT; end
      SYS_ON_BATTERY: begin col = COL_CYAN;    eff = EFF_BREATH;   end
      SYS_LOW_BATT:   begin col = COL_YELLOW;  eff = EFF_BREATH;   end
      SYS_UPDATE:     begin col = COL_MAGENTA; eff = EFF_BLINK;    end
      SYS_ERROR:      begin col = COL_RED;     eff = EFF_BLINK;    end
      SYS_SETUP:      begin col = COL_BLUE;    eff = EFF_CONSTANT; end
      SYS_SLEEP:      begin col = COL_WHITE;   eff = EFF_OFF;      end
      SYS_RESET:      begin col = COL_RED;     eff = EFF_CONSTANT; end
      default:        return;  // unknown states are ignored
    endcase
    if (st == SYS_ON_BATTERY && !led_cfg.idle_state) eff = EFF_OFF;
    led_show(col, eff);
  endfunction

  // {red, green, blue} levels; black for the spare code
  function automatic logic [23:0] color_rgb(logic [2:0] col);
    case (col)
      COL_WHITE:   return {8'd255, 8'd255, 8'd255};
      COL_RED:     return {8'd255, 8'd0,   8'd0};
      COL_YELLOW:  return {8'd255, 8'd255, 8'd0};
      COL_BLUE:    return {8'd0,   8'd0,   8'd255};
      COL_GREEN:   return {8'd0,   8'd255, 8'd0};
      COL_MAGENTA: return {8'd255, 8'd0,   8'd255};
      COL_CYAN:    return {8'd0,   8'd255, 8'd255};
      COL_BLACK:   return '0;
      default:     return '0;
    endcase
  endfunction

  // Saturates at 255 when brightness runs above 100 percent
  function automatic logic [7:0] pwm_level(logic [7:0] comp);
    int unsigned scale;
    int unsigned level;
    scale = led_bright;
    scale = scale * led_cfg.pulse_scale / 100;
    level = scale * comp / 255;
    return (level > 255) ? 8'd255 : 8'(level);
  endfunction

  function automatic led_out_t led_apply(led_cmd_t cmd);
    led_out_t   r;
    logic [23:0] rgb;
    case (cmd.op)
      OP_TICK:  led_tick();
      OP_SHOW:  led_show(cmd.color, cmd.effect);
      OP_EVENT: led_event(cmd.sys_state);
      default:  ;  // unused code: state unchanged
    endcase
    rgb      = color_rgb(led_color);
    r.zero   = '0;
    r.red    = pwm_level(rgb[23:16]);
    r.green  = pwm_level(rgb[15:8]);
    r.blue   = pwm_level(rgb[7:0]);
    r.effect = led_effect;
    r.bright = led_bright;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  led_cmd_t    pending_cmds[$];
  led_out_t    expected_leds[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  bit          in_taken       = 1'b0;
  bit          out_taken      = 1'b0;
  bit          tx_burst       = 1'b0;
  bit          rx_burst       = 1'b0;
  int unsigned send_wait      = 0;
  int unsigned recv_wait      = 0;
  int unsigned hold_left      = 0;
  int unsigned holds_done     = 0;

  // per-transaction wait, with occasional stretches of back-to-back traffic
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [7:0] pick_count();
    return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
  endfunction

  // mostly in-range settings, now and then above the documented ranges
  function automatic cfg_t random_settings();
    cfg_t s;
    s.full_brightness   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                      : 7'($urandom_range(0, 100));
    s.pulse_scale       = 8'($urandom_range(0, 255));
    s.ramp_step         = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(1, 50));
    s.blink_ticks       = pick_count();
    s.fast_blink_ticks  = pick_count();
    s.breath_step_ticks = pick_count();
    s.fast_pause_ticks  = pick_count();
    s.idle_state        = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Ticks dominate so effects get to run; commands reshuffle the state
  function automatic led_cmd_t random_cmd();
    led_cmd_t    c;
    int unsigned r;
    r           = $urandom_range(0, 99);
    c.zero      = '0;
    c.color     = 3'($urandom_range(0, 7));
    c.effect    = 3'($urandom_range(0, 7));
    c.sys_state = 4'($urandom_range(0, 15));
    if (r < 74)      c.op = OP_TICK;
    else if (r < 88) c.op = OP_SHOW;
    else if (r < 96) c.op = OP_EVENT;
    else             c.op = OP_UNUSED;
    return c;
  endfunction

  task automatic write_register(logic [2:0] idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_FULL_BRIGHTNESS:   led_cfg.full_brightness   = value[6:0];
      REG_PULSE_SCALE:       led_cfg.pulse_scale       = value;
      REG_RAMP_STEP:         led_cfg.ramp_step         = value[5:0];
      REG_BLINK_TICKS:       led_cfg.blink_ticks       = value;
      REG_FAST_BLINK_TICKS:  led_cfg.fast_blink_ticks  = value;
      REG_BREATH_STEP_TICKS: led_cfg.breath_step_ticks = value;
      REG_FAST_PAUSE_TICKS:  led_cfg.fast_pause_ticks  = value;
      default:               led_cfg.idle_state        = value[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(cfg_t s);
    write_register(REG_FULL_BRIGHTNESS,   8'(s.full_brightness));
    write_register(REG_PULSE_SCALE,       s.pulse_scale);
    write_register(REG_RAMP_STEP,         8'(s.ramp_step));
    write_register(REG_BLINK_TICKS,       s.blink_ticks);
    write_register(REG_FAST_BLINK_TICKS,  s.fast_blink_ticks);
    write_register(REG_BREATH_STEP_TICKS, s.breath_step_ticks);
    write_register(REG_FAST_PAUSE_TICKS,  s.fast_pause_ticks);
    write_register(REG_IDLE_STATE,        8'(s.idle_state));
  endtask

  // sender stops until every outstanding result has been taken
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_leds.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus: directed opening, then phases of random traffic, each
  // under its own register settings
  // ---------------------------------------------------------------------
  initial begin : stimulus
    led_cmd_t c;
    cfg_t     s;
    int       n;
    int       ph;
    led_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick with nothing animating, then the unused operation code
    c    = '0;
    c.op = OP_TICK;
    pending_cmds.push_back(c);
    c           = '0;
    c.op        = OP_UNUSED;
    c.color     = '1;
    c.effect    = '1;
    c.sys_state = '1;
    pending_cmds.push_back(c);
    // every color and every effect code, spare codes included
    // (black color, unknown effects acting as breath)
    for (n = 0; n < 8; n++) begin
      c        = '0;
      c.op     = OP_SHOW;
      c.color  = 3'(n);
      c.effect = 3'(n);
      pending_cmds.push_back(c);
    end
    // all system states, the unknown ones too
    for (n = 0; n < 16; n++) begin
      c           = random_cmd();
      c.op        = OP_EVENT;
      c.sys_state = 4'(n);
      pending_cmds.push_back(c);
    end
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = '{full_brightness: 7'd127, pulse_scale: 8'd255, ramp_step: 6'd63,
                 blink_ticks: 8'd255, fast_blink_ticks: 8'd255,
                 breath_step_ticks: 8'd255, fast_pause_ticks: 8'd255, idle_state: 1'b1};
        1: s = '0;
        // zero ramp step: a ramp makes no progress, so it stalls
        2: s = '{full_brightness: 7'd100, pulse_scale: 8'd255, ramp_step: 6'd0,
                 blink_ticks: 8'd0, fast_blink_ticks: 8'd0,
                 breath_step_ticks: 8'd0, fast_pause_ticks: 8'd0, idle_state: 1'b1};
        default: s = random_settings();
      endcase
      load_settings(s);
      for (n = 0; n < ITEMS_PER_PHASE; n++) pending_cmds.push_back(random_cmd());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Input driver: presents queued commands at the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (in_taken) begin
        send_wait = draw_gap(tx_burst);
        in_taken  = 1'b0;
      end
      if (send_wait != 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        s_axis_tdata  <= pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output ready: random wait per result, plus two long hold-offs so the
  // command queue fills and the input side stalls
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        recv_wait = draw_gap(rx_burst);
        out_taken = 1'b0;
      end
      if ((holds_done == 0 && results_seen >= HOLD_FIRST) ||
          (holds_done == 1 && results_seen >= HOLD_SECOND)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: predicts on each accepted command, checks each result
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_led(led_out_t got);
    led_out_t want;
    if (expected_leds.size() == 0) begin
      $error("result transaction with nothing expected: %h", got);
      mismatch_count++;
      return;
    end
    want = expected_leds.pop_front();
    check_field("red_compare",    want.red,    got.red);
    check_field("green_compare",  want.green,  got.green);
    check_field("blue_compare",   want.blue,   got.blue);
    check_field("active_effect",  want.effect, got.effect);
    check_field("brightness_now", want.bright, got.bright);
    check_field("padding",        want.zero,   got.zero);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_leds.push_back(led_apply(s_axis_tdata));
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        results_seen++;
        check_led(m_axis_tdata);
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

[rgb_led_effect_controller_unit.f]
+incdir+rtl/core
rtl/core/rlec_pkg.sv
rtl/core/rlec_front.sv
rtl/core/rlec_cmd_fifo.sv
rtl/core/rlec_back.sv
rtl/core/rgb_led_effect_controller_unit.sv
tb/testbench.sv
